// ----- src/tgad_pkg.sv -----
// shared types and constants for the tga truecolor decoder
package tgad_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int OFFSET_W    = 34;

    localparam logic [4:0]  HEADER_LAST          = 5'd17;
    localparam logic [4:0]  HDR_ID_LENGTH        = 5'd0;
    localparam logic [4:0]  HDR_MAP_TYPE         = 5'd1;
    localparam logic [4:0]  HDR_IMAGE_TYPE       = 5'd2;
    localparam logic [4:0]  HDR_WIDTH_LO         = 5'd12;
    localparam logic [4:0]  HDR_WIDTH_HI         = 5'd13;
    localparam logic [4:0]  HDR_HEIGHT_LO        = 5'd14;
    localparam logic [4:0]  HDR_HEIGHT_HI        = 5'd15;
    localparam logic [4:0]  HDR_PIXEL_DEPTH      = 5'd16;
    localparam logic [7:0]  IMAGE_TYPE_TRUECOLOR = 8'd2;
    localparam logic [7:0]  DEPTH_15             = 8'd15;
    localparam logic [7:0]  DEPTH_16             = 8'd16;
    localparam logic [7:0]  DEPTH_24             = 8'd24;
    localparam logic [7:0]  DEPTH_32             = 8'd32;

    localparam logic [15:0] RED_MASK       = 16'h7C00;
    localparam logic [15:0] GREEN_MASK     = 16'h03E0;
    localparam logic [15:0] BLUE_MASK      = 16'h001F;
    localparam logic [15:0] ALPHA_BIT_MASK = 16'h8000;
    localparam logic [7:0]  ALPHA_OPAQUE   = 8'hFF;
    localparam logic [OFFSET_W-1:0] PIXEL_STEP = OFFSET_W'(4);

    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_MAP   = 2'd1,
        KIND_TYPE  = 2'd2,
        KIND_DEPTH = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        FMT_15,
        FMT_16,
        FMT_24,
        FMT_32
    } t_fmt;

    // one classified pixel or error, handed from front to back
    typedef struct packed {
        t_kind               kind;
        t_fmt                fmt;
        logic [23:0]         hold;
        logic [7:0]          tail;
        logic [15:0]         column;
        logic [15:0]         row;
        logic [OFFSET_W-1:0] offset;
        logic                last;
    } t_job;

endpackage

// ----- src/tgad_front.sv -----
// header parser and pixel assembler: turns file bytes into pixel or error jobs
module tgad_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_file_byte,
    input  logic          i_first_byte,
    output logic          o_job_valid,
    output tgad_pkg::t_job o_job
);
    import tgad_pkg::*;

    typedef enum logic [1:0] {PH_HEADER, PH_SKIP, PH_PIXEL, PH_DONE} t_phase;

    t_phase              r_phase, c_phase, n_phase;
    logic [4:0]          r_hdr_cnt, c_hdr_cnt, n_hdr_cnt;
    logic [7:0]          r_id_len, c_id_len, n_id_len;
    logic [7:0]          r_map_type, c_map_type, n_map_type;
    logic [7:0]          r_img_type, c_img_type, n_img_type;
    logic [15:0]         r_width, c_width, n_width;
    logic [15:0]         r_height, c_height, n_height;
    logic [7:0]          r_depth, c_depth, n_depth;
    logic [7:0]          r_skip, c_skip, n_skip;
    logic [1:0]          r_bidx, c_bidx, n_bidx;
    logic [23:0]         r_hold, c_hold, n_hold;
    logic [15:0]         r_col, c_col, n_col;
    logic [15:0]         r_row, c_row, n_row;
    logic [OFFSET_W-1:0] r_off, c_off, n_off;

    logic        fmt_ok;
    t_fmt        fmt;
    logic [2:0]  bpp;
    logic        do_start;
    logic        is_last;
    logic [16:0] col_next;
    logic [16:0] row_next;

    // a first-byte mark restarts from the cleared state
    always_comb begin
        c_phase    = i_first_byte ? PH_HEADER : r_phase;
        c_hdr_cnt  = i_first_byte ? '0 : r_hdr_cnt;
        c_id_len   = i_first_byte ? '0 : r_id_len;
        c_map_type = i_first_byte ? '0 : r_map_type;
        c_img_type = i_first_byte ? '0 : r_img_type;
        c_width    = i_first_byte ? '0 : r_width;
        c_height   = i_first_byte ? '0 : r_height;
        c_depth    = i_first_byte ? '0 : r_depth;
        c_skip     = i_first_byte ? '0 : r_skip;
        c_bidx     = i_first_byte ? '0 : r_bidx;
        c_hold     = i_first_byte ? '0 : r_hold;
        c_col      = i_first_byte ? '0 : r_col;
        c_row      = i_first_byte ? '0 : r_row;
        c_off      = i_first_byte ? '0 : r_off;
    end

    always_comb begin
        fmt_ok = 1'b1;
        fmt    = FMT_24;
        bpp    = 3'd3;
        if (c_depth == DEPTH_15) begin
            fmt = FMT_15;
            bpp = 3'd2;
        end else if (c_depth == DEPTH_16) begin
            fmt = FMT_16;
            bpp = 3'd2;
        end else if (c_depth == DEPTH_24) begin
            fmt = FMT_24;
            bpp = 3'd3;
        end else if (c_depth == DEPTH_32) begin
            fmt = FMT_32;
            bpp = 3'd4;
        end else begin
            fmt_ok = 1'b0;
        end
    end

    assign col_next = {1'b0, c_col} + 17'd1;
    assign row_next = {1'b0, c_row} + 17'd1;
    assign is_last  = (col_next == {1'b0, c_width}) && (row_next == {1'b0, c_height});

    always_comb begin
        n_phase    = c_phase;
        n_hdr_cnt  = c_hdr_cnt;
        n_id_len   = c_id_len;
        n_map_type = c_map_type;
        n_img_type = c_img_type;
        n_width    = c_width;
        n_height   = c_height;
        n_depth    = c_depth;
        n_skip     = c_skip;
        n_bidx     = c_bidx;
        n_hold     = c_hold;
        n_col      = c_col;
        n_row      = c_row;
        n_off      = c_off;
        do_start   = 1'b0;
        o_job_valid = 1'b0;
        o_job       = '0;

        case (c_phase)
            PH_HEADER: begin
                case (c_hdr_cnt)
                    HDR_ID_LENGTH:   n_id_len        = i_file_byte;
                    HDR_MAP_TYPE:    n_map_type      = i_file_byte;
                    HDR_IMAGE_TYPE:  n_img_type      = i_file_byte;
                    HDR_WIDTH_LO:    n_width[7:0]    = i_file_byte;
                    HDR_WIDTH_HI:    n_width[15:8]   = i_file_byte;
                    HDR_HEIGHT_LO:   n_height[7:0]   = i_file_byte;
                    HDR_HEIGHT_HI:   n_height[15:8]  = i_file_byte;
                    HDR_PIXEL_DEPTH: n_depth         = i_file_byte;
                    default: ;
                endcase
                if (c_hdr_cnt < HEADER_LAST) begin
                    n_hdr_cnt = c_hdr_cnt + 5'd1;
                end else if (c_map_type != 8'd0 || c_img_type != IMAGE_TYPE_TRUECOLOR
                             || !fmt_ok) begin
                    o_job_valid = 1'b1;
                    o_job.last  = 1'b1;
                    if (c_map_type != 8'd0) begin
                        o_job.kind = KIND_MAP;
                    end else if (c_img_type != IMAGE_TYPE_TRUECOLOR) begin
                        o_job.kind = KIND_TYPE;
                    end else begin
                        o_job.kind = KIND_DEPTH;
                    end
                    n_phase = PH_DONE;
                end else if (c_id_len != 8'd0) begin
                    n_skip  = c_id_len;
                    n_phase = PH_SKIP;
                end else begin
                    do_start = 1'b1;
                end
            end
            PH_SKIP: begin
                n_skip = c_skip - 8'd1;
                if (n_skip == 8'd0) begin
                    do_start = 1'b1;
                end
            end
            PH_PIXEL: begin
                if (!fmt_ok) begin
                    n_phase = PH_DONE;
                end else if ({1'b0, c_bidx} + 3'd1 < bpp) begin
                    case (c_bidx)
                        2'd0:    n_hold[7:0]   = i_file_byte;
                        2'd1:    n_hold[15:8]  = i_file_byte;
                        2'd2:    n_hold[23:16] = i_file_byte;
                        default: ;
                    endcase
                    n_bidx = c_bidx + 2'd1;
                end else begin
                    o_job_valid  = 1'b1;
                    o_job.kind   = KIND_PIXEL;
                    o_job.fmt    = fmt;
                    o_job.hold   = c_hold;
                    o_job.tail   = i_file_byte;
                    o_job.column = c_col;
                    o_job.row    = c_row;
                    o_job.offset = c_off;
                    o_job.last   = is_last;
                    n_bidx = '0;
                    n_hold = '0;
                    n_off  = c_off + PIXEL_STEP;
                    if (col_next >= {1'b0, c_width}) begin
                        n_col = '0;
                        n_row = row_next[15:0];
                    end else begin
                        n_col = col_next[15:0];
                    end
                    if (is_last) begin
                        n_phase = PH_DONE;
                    end
                end
            end
            default: ;
        endcase

        if (do_start) begin
            n_bidx  = '0;
            n_hold  = '0;
            n_col   = '0;
            n_row   = '0;
            n_off   = '0;
            n_phase = (c_width == 16'd0 || c_height == 16'd0) ? PH_DONE : PH_PIXEL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hdr_cnt  <= '0;
            r_id_len   <= '0;
            r_map_type <= '0;
            r_img_type <= '0;
            r_width    <= '0;
            r_height   <= '0;
            r_depth    <= '0;
            r_skip     <= '0;
            r_bidx     <= '0;
            r_hold     <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_off      <= '0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_hdr_cnt  <= n_hdr_cnt;
            r_id_len   <= n_id_len;
            r_map_type <= n_map_type;
            r_img_type <= n_img_type;
            r_width    <= n_width;
            r_height   <= n_height;
            r_depth    <= n_depth;
            r_skip     <= n_skip;
            r_bidx     <= n_bidx;
            r_hold     <= n_hold;
            r_col      <= n_col;
            r_row      <= n_row;
            r_off      <= n_off;
        end
    end

endmodule

// ----- src/tgad_fifo.sv -----
// short job queue between the parser and the pixel formatter
module tgad_fifo #(
    parameter int DEPTH = tgad_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tgad_pkg::t_job i_data,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output tgad_pkg::t_job o_data
);
    import tgad_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- src/tgad_back.sv -----
// pixel formatter: unpacks a job into rgba and holds it in the output register
module tgad_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_empty,
    input  tgad_pkg::t_job i_job,
    output logic           o_job_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [1:0]     o_kind,
    output logic [7:0]     o_red,
    output logic [7:0]     o_green,
    output logic [7:0]     o_blue,
    output logic [7:0]     o_alpha,
    output logic [15:0]    o_column,
    output logic [15:0]    o_row,
    output logic [tgad_pkg::OFFSET_W-1:0] o_byte_offset,
    output logic           o_last
);
    import tgad_pkg::*;

    logic        r_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_red, r_green, r_blue, r_alpha;
    logic [15:0] r_column, r_row;
    logic [OFFSET_W-1:0] r_offset;
    logic        r_last;

    logic [7:0]  n_red, n_green, n_blue, n_alpha;
    logic [15:0] packed16;
    logic        load;

    // output register frees when empty or when its beat is taken this cycle
    assign load      = !i_job_empty && (!r_valid || i_pop);
    assign o_job_pop = load;
    assign packed16  = {i_job.tail, i_job.hold[7:0]};

    always_comb begin
        n_red   = '0;
        n_green = '0;
        n_blue  = '0;
        n_alpha = '0;
        if (i_job.kind == KIND_PIXEL) begin
            case (i_job.fmt)
                FMT_15, FMT_16: begin
                    n_red   = 8'((packed16 & RED_MASK) >> 10);
                    n_green = 8'((packed16 & GREEN_MASK) >> 5);
                    n_blue  = 8'(packed16 & BLUE_MASK);
                    if (i_job.fmt == FMT_16) begin
                        n_alpha = ((packed16 & ALPHA_BIT_MASK) != 16'd0) ? ALPHA_OPAQUE : 8'd0;
                    end else begin
                        n_alpha = ALPHA_OPAQUE;
                    end
                end
                FMT_24: begin
                    n_red   = i_job.hold[7:0];
                    n_green = i_job.hold[15:8];
                    n_blue  = i_job.tail;
                    n_alpha = ALPHA_OPAQUE;
                end
                FMT_32: begin
                    n_red   = i_job.hold[7:0];
                    n_green = i_job.hold[15:8];
                    n_blue  = i_job.hold[23:16];
                    n_alpha = i_job.tail;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= i_job.kind;
            r_red    <= n_red;
            r_green  <= n_green;
            r_blue   <= n_blue;
            r_alpha  <= n_alpha;
            r_column <= (i_job.kind == KIND_PIXEL) ? i_job.column : 16'd0;
            r_row    <= (i_job.kind == KIND_PIXEL) ? i_job.row : 16'd0;
            r_offset <= (i_job.kind == KIND_PIXEL) ? i_job.offset : '0;
            r_last   <= i_job.last;
        end
    end

    assign o_empty       = !r_valid;
    assign o_kind        = r_kind;
    assign o_red         = r_red;
    assign o_green       = r_green;
    assign o_blue        = r_blue;
    assign o_alpha       = r_alpha;
    assign o_column      = r_column;
    assign o_row         = r_row;
    assign o_byte_offset = r_offset;
    assign o_last        = r_last;

endmodule

// ----- src/tga_truecolor_decoder.sv -----
// top level of the tga truecolor decoder: parser, job queue and pixel formatter
// throughput: one file byte per cycle until a stalled result side fills the job queue
// a result's job enters the queue at the edge that takes its last byte and moves into
// the output register once that register is empty or its beat is being popped
// reset: synchronous active-low reset clears the parse state, the queue and the output
// register's valid flag; the first byte after reset is taken as header byte 0
module tga_truecolor_decoder #(
    parameter int QUEUE_DEPTH = tgad_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_file_byte,
    input  logic        i_first_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [15:0] o_column,
    output logic [15:0] o_row,
    output logic [tgad_pkg::OFFSET_W-1:0] o_byte_offset,
    output logic        o_last
);
    import tgad_pkg::*;

    logic accept;
    logic job_valid;
    t_job front_job;
    t_job queue_job;
    logic queue_full;
    logic queue_empty;
    logic queue_pop;

    assign full   = queue_full;
    assign accept = push && !queue_full;

    tgad_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_file_byte  (i_file_byte),
        .i_first_byte (i_first_byte),
        .o_job_valid  (job_valid),
        .o_job        (front_job)
    );

    tgad_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && job_valid),
        .i_data  (front_job),
        .i_pop   (queue_pop),
        .o_full  (queue_full),
        .o_empty (queue_empty),
        .o_data  (queue_job)
    );

    tgad_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_empty   (queue_empty),
        .i_job         (queue_job),
        .o_job_pop     (queue_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_kind        (o_kind),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_column      (o_column),
        .o_row         (o_row),
        .o_byte_offset (o_byte_offset),
        .o_last        (o_last)
    );

endmodule

// ----- src/tgad_checker.sv -----
// port-level checks for the tga truecolor decoder, bound to the top level
module tgad_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_red,
    input logic [7:0]  o_green,
    input logic [7:0]  o_blue,
    input logic [7:0]  o_alpha,
    input logic [15:0] o_column,
    input logic [15:0] o_row,
    input logic [tgad_pkg::OFFSET_W-1:0] o_byte_offset,
    input logic        o_last
);
    import tgad_pkg::*;

    // nothing is waiting right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) $past(!i_rst_n) |-> empty)
        else $error("result shown right after reset");

    // an error beat carries only its kind and the last mark
    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind != KIND_PIXEL) |-> (o_last && o_red == 8'd0 && o_green == 8'd0
            && o_blue == 8'd0 && o_alpha == 8'd0 && o_column == 16'd0 && o_row == 16'd0
            && o_byte_offset == '0))
        else $error("error beat with nonzero pixel fields");

    // four bytes per output pixel, so offsets stay word aligned
    a_offset_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_byte_offset[1:0] == 2'd0))
        else $error("byte offset not word aligned");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_kind) && $stable(o_red)
            && $stable(o_green) && $stable(o_blue) && $stable(o_alpha)
            && $stable(o_column) && $stable(o_row) && $stable(o_byte_offset)
            && $stable(o_last)))
        else $error("stalled result changed");

endmodule

bind tga_truecolor_decoder tgad_checker u_tgad_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_kind        (o_kind),
    .o_red         (o_red),
    .o_green       (o_green),
    .o_blue        (o_blue),
    .o_alpha       (o_alpha),
    .o_column      (o_column),
    .o_row         (o_row),
    .o_byte_offset (o_byte_offset),
    .o_last        (o_last)
);

// ----- tb/sv/tgad_result_checker.sv -----
// checker for the tga truecolor decoder: predicts every beat taken and compares each result
module tgad_result_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_full,
    input  logic [7:0]          i_file_byte,
    input  logic                i_first_byte,
    input  logic                i_empty,
    input  logic                i_pop,
    input  logic [1:0]          i_kind,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    input  logic [7:0]          i_alpha,
    input  logic [15:0]         i_column,
    input  logic [15:0]         i_row,
    input  logic [tgad_pkg::OFFSET_W-1:0] i_byte_offset,
    input  logic                i_last,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_results,
    output int                  o_errors
);
    import tgad_pkg::*;

    typedef enum logic [1:0] {
        ST_HEADER,
        ST_SKIP,
        ST_PIXEL,
        ST_DONE
    } t_parse;

    typedef struct packed {
        t_kind               kind;
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
        logic [7:0]          alpha;
        logic [15:0]         column;
        logic [15:0]         row;
        logic [OFFSET_W-1:0] offset;
        logic                last;
    } t_decoded;

    t_parse              parse_st;
    logic [4:0]          hdr_idx;
    logic [7:0]          id_len;
    logic [7:0]          map_type;
    logic [7:0]          img_type;
    logic [7:0]          depth;
    logic [7:0]          skip_left;
    logic [15:0]         width;
    logic [15:0]         height;
    logic [1:0]          byte_idx;
    logic [23:0]         hold;
    logic [15:0]         col;
    logic [15:0]         row;
    logic [OFFSET_W-1:0] offset;

    t_decoded decoded_q[$];
    t_decoded new_res;
    t_decoded want_res;
    bit       made_one;
    int       field_errs;
    int       fail_cnt   = 0;
    int       result_cnt = 0;
    int       error_cnt  = 0;

    function automatic int unsigned depth_bytes(input logic [7:0] d);
        case (d)
            DEPTH_15, DEPTH_16: return 2;
            DEPTH_24:           return 3;
            DEPTH_32:           return 4;
            default:            return 0;
        endcase
    endfunction

    task automatic clear_parse();
        parse_st  = ST_HEADER;
        hdr_idx   = '0;
        id_len    = '0;
        map_type  = '0;
        img_type  = '0;
        depth     = '0;
        skip_left = '0;
        width     = '0;
        height    = '0;
        byte_idx  = '0;
        hold      = '0;
        col       = '0;
        row       = '0;
        offset    = '0;
    endtask

    task automatic begin_pixels();
        byte_idx = '0;
        hold     = '0;
        col      = '0;
        row      = '0;
        offset   = '0;
        parse_st = (width == 16'd0 || height == 16'd0) ? ST_DONE : ST_PIXEL;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic mark,
                               output bit produced, output t_decoded res);
        int unsigned nb;
        logic [15:0] word;
        logic [16:0] col_n;
        logic [16:0] row_n;
        t_kind       err;
        produced = 1'b0;
        res      = '0;
        if (mark)
            clear_parse();
        case (parse_st)
            ST_HEADER: begin
                case (hdr_idx)
                    HDR_ID_LENGTH:   id_len       = b;
                    HDR_MAP_TYPE:    map_type     = b;
                    HDR_IMAGE_TYPE:  img_type     = b;
                    HDR_WIDTH_LO:    width[7:0]   = b;
                    HDR_WIDTH_HI:    width[15:8]  = b;
                    HDR_HEIGHT_LO:   height[7:0]  = b;
                    HDR_HEIGHT_HI:   height[15:8] = b;
                    HDR_PIXEL_DEPTH: depth        = b;
                    default: ;
                endcase
                if (hdr_idx < HEADER_LAST) begin
                    hdr_idx = hdr_idx + 5'd1;
                end else begin
                    // header checks in priority order: map, type, depth
                    err = KIND_PIXEL;
                    if (map_type != 8'd0)
                        err = KIND_MAP;
                    else if (img_type != IMAGE_TYPE_TRUECOLOR)
                        err = KIND_TYPE;
                    else if (depth_bytes(depth) == 0)
                        err = KIND_DEPTH;
                    if (err != KIND_PIXEL) begin
                        produced = 1'b1;
                        res.kind = err;
                        res.last = 1'b1;
                        parse_st = ST_DONE;
                    end else if (id_len != 8'd0) begin
                        skip_left = id_len;
                        parse_st  = ST_SKIP;
                    end else begin
                        begin_pixels();
                    end
                end
            end
            ST_SKIP: begin
                skip_left = skip_left - 8'd1;
                if (skip_left == 8'd0)
                    begin_pixels();
            end
            ST_PIXEL: begin
                nb = depth_bytes(depth);
                if (nb == 0) begin
                    parse_st = ST_DONE;
                end else if (int'(byte_idx) + 1 < nb) begin
                    hold     = hold | (24'(b) << (8 * byte_idx));
                    byte_idx = byte_idx + 2'd1;
                end else begin
                    produced = 1'b1;
                    res.kind = KIND_PIXEL;
                    if (nb == 2) begin
                        // little-endian 5:5:5 word, channels left unwidened
                        word      = {b, hold[7:0]};
                        res.red   = {3'b000, word[14:10]};
                        res.green = {3'b000, word[9:5]};
                        res.blue  = {3'b000, word[4:0]};
                        if (depth == DEPTH_16)
                            res.alpha = word[15] ? ALPHA_OPAQUE : 8'h00;
                        else
                            res.alpha = ALPHA_OPAQUE;
                    end else begin
                        res.red   = hold[7:0];
                        res.green = hold[15:8];
                        if (nb == 3) begin
                            res.blue  = b;
                            res.alpha = ALPHA_OPAQUE;
                        end else begin
                            res.blue  = hold[23:16];
                            res.alpha = b;
                        end
                    end
                    col_n      = {1'b0, col} + 17'd1;
                    row_n      = {1'b0, row} + 17'd1;
                    res.last   = (col_n == {1'b0, width}) && (row_n == {1'b0, height});
                    res.column = col;
                    res.row    = row;
                    res.offset = offset;
                    byte_idx   = '0;
                    hold       = '0;
                    offset     = offset + OFFSET_W'(4);
                    if (col_n >= {1'b0, width}) begin
                        col = '0;
                        row = row + 16'd1;
                    end else begin
                        col = col_n[15:0];
                    end
                    if (res.last)
                        parse_st = ST_DONE;
                end
            end
            default: ;
        endcase
    endtask

    task automatic cmp_field(input string name, input logic [OFFSET_W-1:0] want,
                             input logic [OFFSET_W-1:0] got, inout int errs);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errs++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            decoded_q.delete();
        end else begin
            if (i_pop && !i_empty) begin
                result_cnt++;
                if (i_last && i_kind != KIND_PIXEL)
                    error_cnt++;
                if (decoded_q.size() == 0) begin
                    $display("%0t: result beat with nothing pending, kind %0d col %0d row %0d",
                             $time, i_kind, i_column, i_row);
                    fail_cnt++;
                end else begin
                    want_res   = decoded_q.pop_front();
                    field_errs = 0;
                    cmp_field("kind",        OFFSET_W'(want_res.kind),   OFFSET_W'(i_kind),
                              field_errs);
                    cmp_field("red",         OFFSET_W'(want_res.red),    OFFSET_W'(i_red),
                              field_errs);
                    cmp_field("green",       OFFSET_W'(want_res.green),  OFFSET_W'(i_green),
                              field_errs);
                    cmp_field("blue",        OFFSET_W'(want_res.blue),   OFFSET_W'(i_blue),
                              field_errs);
                    cmp_field("alpha",       OFFSET_W'(want_res.alpha),  OFFSET_W'(i_alpha),
                              field_errs);
                    cmp_field("column",      OFFSET_W'(want_res.column), OFFSET_W'(i_column),
                              field_errs);
                    cmp_field("row",         OFFSET_W'(want_res.row),    OFFSET_W'(i_row),
                              field_errs);
                    cmp_field("byte_offset", want_res.offset,            i_byte_offset,
                              field_errs);
                    cmp_field("last",        OFFSET_W'(want_res.last),   OFFSET_W'(i_last),
                              field_errs);
                    if (field_errs != 0)
                        fail_cnt++;
                end
            end
            if (i_push && !i_full) begin
                decode_byte(i_file_byte, i_first_byte, made_one, new_res);
                if (made_one)
                    decoded_q.push_back(new_res);
            end
        end
        o_pending    <= decoded_q.size();
        o_fail_count <= fail_cnt;
        o_results    <= result_cnt;
        o_errors     <= error_cnt;
    end

endmodule

// ----- tb/sv/tb_tga_truecolor_decoder.sv -----
// testbench top for the tga truecolor decoder: byte stimulus, result draining and verdict
module tb_tga_truecolor_decoder;
    import tgad_pkg::*;

    localparam int LONG_HOLD   = 200;
    localparam int STALL_LIMIT = 2000;

    logic                i_clk;
    logic                i_rst_n;
    logic                push;
    logic                full;
    logic [7:0]          i_file_byte;
    logic                i_first_byte;
    logic                empty;
    logic                pop;
    logic [1:0]          o_kind;
    logic [7:0]          o_red;
    logic [7:0]          o_green;
    logic [7:0]          o_blue;
    logic [7:0]          o_alpha;
    logic [15:0]         o_column;
    logic [15:0]         o_row;
    logic [OFFSET_W-1:0] o_byte_offset;
    logic                o_last;

    int fail_count;
    int pending;
    int results;
    int errors;

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit hold_req   = 1'b0;
    int bytes_sent = 0;
    int files_sent = 0;
    int stall_cnt  = 0;

    tga_truecolor_decoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_file_byte   (i_file_byte),
        .i_first_byte  (i_first_byte),
        .empty         (empty),
        .pop           (pop),
        .o_kind        (o_kind),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_column      (o_column),
        .o_row         (o_row),
        .o_byte_offset (o_byte_offset),
        .o_last        (o_last)
    );

    tgad_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_file_byte   (i_file_byte),
        .i_first_byte  (i_first_byte),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_kind        (o_kind),
        .i_red         (o_red),
        .i_green       (o_green),
        .i_blue        (o_blue),
        .i_alpha       (o_alpha),
        .i_column      (o_column),
        .i_row         (o_row),
        .i_byte_offset (o_byte_offset),
        .i_last        (o_last),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (results),
        .o_errors      (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(0, 9)) @(negedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // watchdog: cycles in which no beat moves on either side
    initial begin
        while (stall_cnt < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || !i_rst_n)
                stall_cnt = 0;
            else
                stall_cnt++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_beat(input logic [7:0] b, input logic mark);
        int gap;
        @(negedge i_clk);
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            push <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(negedge i_clk);
        end
        push         <= 1'b1;
        i_file_byte  <= b;
        i_first_byte <= mark;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_header(input logic [7:0] idl, input logic [7:0] map,
                               input logic [7:0] ity, input logic [15:0] w,
                               input logic [15:0] h, input logic [7:0] dep,
                               input logic mark);
        send_beat(idl, mark);
        send_beat(map, 1'b0);
        send_beat(ity, 1'b0);
        // map spec and origin bytes carry nothing the decoder uses
        repeat (9) send_beat(8'($urandom), 1'b0);
        send_beat(w[7:0], 1'b0);
        send_beat(w[15:8], 1'b0);
        send_beat(h[7:0], 1'b0);
        send_beat(h[15:8], 1'b0);
        send_beat(dep, 1'b0);
        send_beat(8'($urandom), 1'b0);
    endtask

    // cut < 0 sends the whole body; tail bytes follow the body
    task automatic send_file(input logic [7:0] idl, input logic [7:0] map,
                             input logic [7:0] ity, input logic [15:0] w,
                             input logic [15:0] h, input logic [7:0] dep,
                             input logic mark, input int cut, input int tail);
        longint nb;
        longint total;
        send_header(idl, map, ity, w, h, dep, mark);
        case (dep)
            DEPTH_15, DEPTH_16: nb = 2;
            DEPTH_24:           nb = 3;
            DEPTH_32:           nb = 4;
            default:            nb = 0;
        endcase
        if (map != 8'd0 || ity != IMAGE_TYPE_TRUECOLOR)
            nb = 0;
        total = (nb == 0) ? 0 : longint'(idl) + longint'(w) * longint'(h) * nb;
        if (cut >= 0 && cut < total)
            total = cut;
        repeat (total) send_beat(8'($urandom), 1'b0);
        repeat (tail) send_beat(8'($urandom), 1'b0);
        files_sent++;
    endtask

    task automatic send_word_image(input logic [7:0] dep);
        logic [15:0] words [4];
        words = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
        send_header(8'd0, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'd2, 16'd2, dep, 1'b1);
        foreach (words[i]) begin
            send_beat(words[i][7:0], 1'b0);
            send_beat(words[i][15:8], 1'b0);
        end
        files_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        wait (pending == 0);
    endtask

    initial begin
        int          rand_start;
        int          r;
        int          cut;
        int          tail;
        logic [7:0]  idl;
        logic [7:0]  map;
        logic [7:0]  ity;
        logic [7:0]  dep;
        logic [15:0] w;
        logic [15:0] h;
        logic        mark;

        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_file_byte  = 8'h00;
        i_first_byte = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // a stream with no start mark still parses after reset
        send_file(8'd0, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'd1, 16'd1, DEPTH_24, 1'b0, -1, 2);
        // header checks, each with trailing bytes that must be ignored
        send_file(8'd0, 8'd1, 8'd3, 16'd2, 16'd2, 8'd8, 1'b1, -1, 3);
        send_file(8'd0, 8'd0, 8'd3, 16'd2, 16'd2, 8'd8, 1'b1, -1, 3);
        send_file(8'd0, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'd2, 16'd2, 8'd8, 1'b1, -1, 3);
        // empty images
        send_file(8'd0, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'd0, 16'd3, DEPTH_24, 1'b1, -1, 4);
        send_file(8'd2, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'd3, 16'd0, DEPTH_16, 1'b1, -1, 4);
        send_word_image(DEPTH_16);
        send_word_image(DEPTH_15);
        send_file(8'd40, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'd2, 16'd1, DEPTH_32, 1'b1, -1, 0);
        send_file(8'd1, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'd3, 16'd2, DEPTH_24, 1'b1, -1, 0);
        // restart in mid-header, then in mid-pixel
        send_beat(8'd0, 1'b1);
        repeat (6) send_beat(8'($urandom), 1'b0);
        send_file(8'd0, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'd4, 16'd4, DEPTH_32, 1'b1, 9, 0);
        send_file(8'd0, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'hFFFF, 16'hFFFF, DEPTH_32, 1'b1, 24, 0);
        send_file(8'd0, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'd1, 16'd12, DEPTH_15, 1'b1, -1, 0);

        // long result hold-off while bytes keep coming, then a full drain
        hold_req = 1'b1;
        send_file(8'd0, 8'd0, IMAGE_TYPE_TRUECOLOR, 16'd4, 16'd4, DEPTH_16, 1'b1, -1, 0);
        drain();

        rand_start = bytes_sent;
        while (bytes_sent - rand_start < 150) begin
            if (bytes_sent - rand_start > 110) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            r   = $urandom_range(0, 19);
            map = (r == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
            ity = (r == 1) ? 8'($urandom) : IMAGE_TYPE_TRUECOLOR;
            case ($urandom_range(0, 3))
                0:       dep = DEPTH_15;
                1:       dep = DEPTH_16;
                2:       dep = DEPTH_24;
                default: dep = DEPTH_32;
            endcase
            if (r == 2)
                dep = 8'($urandom);
            w    = (r == 3) ? 16'd0 : 16'($urandom_range(1, 6));
            h    = (r == 6) ? 16'd0 : 16'($urandom_range(1, 5));
            idl  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 6)) : 8'd0;
            cut  = (r == 4) ? $urandom_range(0, 10) : -1;
            tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
            mark = (r != 5);
            send_file(idl, map, ity, w, h, dep, mark, cut, tail);
            if ($urandom_range(0, 15) == 0)
                drain();
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("covered %0d file bytes in %0d files: %0d results, %0d of them header errors",
                 bytes_sent, files_sent, results, errors);
        if (pending != 0)
            $display("%0t: %0d results still pending at the end", $time, pending);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/tgad_pkg.sv
src/tgad_front.sv
src/tgad_fifo.sv
src/tgad_back.sv
src/tga_truecolor_decoder.sv
src/tgad_checker.sv
tb/sv/tgad_result_checker.sv
tb/sv/tb_tga_truecolor_decoder.sv
